// File: hw/rtl/sequenced_trace_ring_buffer_assert.svh
// assertion macros for the trace ring buffer
`ifndef SEQUENCED_TRACE_RING_BUFFER_ASSERT_SVH
`define SEQUENCED_TRACE_RING_BUFFER_ASSERT_SVH

`ifndef SYNTHESIS
`define STRB_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("strb check failed");
`define STRB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("strb check failed");
`else
`define STRB_ASSERT(lbl, expr)
`define STRB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/strb_pkg.sv
package strb_pkg;

    localparam int SEQ_W       = 32;
    localparam int PAY_W       = 32;
    localparam int CNT_W       = 7;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 168;

    localparam logic OP_APPEND  = 1'b0;
    localparam logic OP_COLLECT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_READ,
        ST_CHECK,
        ST_FLUSH,
        ST_EMPTY
    } t_state;

    typedef enum logic [1:0] {
        PUSH_NONE,
        PUSH_PEND,
        PUSH_PEND_LAST,
        PUSH_EMPTY
    } t_push;

    typedef struct packed {
        logic  append;
        logic  start;
        logic  take;
        logic  advance;
        t_push push;
    } t_cmd;

    typedef struct packed {
        logic cap_zero;
        logic collect_empty;
        logic match;
        logic scan_end;
        logic limit_hit;
        logic pend_valid;
        logic out_free;
    } t_stat;

endpackage

// File: hw/rtl/strb_ctrl.sv
module strb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_op,
    output logic            o_in_ready,
    input  strb_pkg::t_stat i_stat,
    output strb_pkg::t_cmd  o_cmd
);

    strb_pkg::t_state r_state;
    strb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= strb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.append  = 1'b0;
        o_cmd.start   = 1'b0;
        o_cmd.take    = 1'b0;
        o_cmd.advance = 1'b0;
        o_cmd.push    = strb_pkg::PUSH_NONE;
        o_in_ready    = (r_state == strb_pkg::ST_IDLE);
        case (r_state)
            strb_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_op == strb_pkg::OP_APPEND) begin
                        if (i_stat.cap_zero) begin
                            n_state = strb_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.append = 1'b1;
                            n_state      = strb_pkg::ST_APPEND;
                        end
                    end else if (i_stat.collect_empty) begin
                        n_state = strb_pkg::ST_EMPTY;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = strb_pkg::ST_READ;
                    end
                end
            end
            strb_pkg::ST_APPEND: begin
                if (i_stat.out_free) begin
                    o_cmd.push = strb_pkg::PUSH_PEND_LAST;
                    n_state    = strb_pkg::ST_IDLE;
                end
            end
            strb_pkg::ST_READ: begin
                n_state = strb_pkg::ST_CHECK;
            end
            strb_pkg::ST_CHECK: begin
                if (i_stat.match) begin
                    if (!i_stat.pend_valid || i_stat.out_free) begin
                        if (i_stat.pend_valid) begin
                            o_cmd.push = strb_pkg::PUSH_PEND;
                        end
                        o_cmd.take = 1'b1;
                        if (i_stat.limit_hit || i_stat.scan_end) begin
                            n_state = strb_pkg::ST_FLUSH;
                        end else begin
                            o_cmd.advance = 1'b1;
                            n_state       = strb_pkg::ST_READ;
                        end
                    end
                end else if (i_stat.scan_end) begin
                    n_state = i_stat.pend_valid ? strb_pkg::ST_FLUSH : strb_pkg::ST_EMPTY;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = strb_pkg::ST_READ;
                end
            end
            strb_pkg::ST_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.push = strb_pkg::PUSH_PEND_LAST;
                    n_state    = strb_pkg::ST_IDLE;
                end
            end
            strb_pkg::ST_EMPTY: begin
                if (i_stat.out_free) begin
                    o_cmd.push = strb_pkg::PUSH_EMPTY;
                    n_state    = strb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = strb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/strb_datapath.sv
`include "sequenced_trace_ring_buffer_assert.svh"

module strb_datapath #(
    parameter int MAX_ENTRIES  = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [strb_pkg::CNT_W-1:0]           i_cfg_wdata,
    input  logic [strb_pkg::PAY_W-1:0]           i_payload,
    input  logic [strb_pkg::SEQ_W-1:0]           i_after_seq,
    input  logic [strb_pkg::CNT_W-1:0]           i_max_out,
    input  strb_pkg::t_cmd                       i_cmd,
    output strb_pkg::t_stat                      o_stat,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [strb_pkg::OUT_TDATA_W-1:0]     o_out_data,
    output logic                                 o_out_last,
    output logic                                 o_out_user
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = strb_pkg::CNT_W;
    localparam int SW = strb_pkg::SEQ_W;
    localparam int PW = strb_pkg::PAY_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    logic [CW-1:0]           r_cap;
    logic [CW-1:0]           act_cap;
    logic [CW-1:0]           limit_in;
    logic [AW-1:0]           r_wp;
    logic [AW-1:0]           wp_inc;
    logic [AW-1:0]           r_slot;
    logic [AW-1:0]           slot_inc;
    logic [AW-1:0]           oldest_slot;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_i;
    logic [CW-1:0]           r_n;
    logic [CW-1:0]           r_limit;
    logic [SW-1:0]           r_next;
    logic [SW-1:0]           r_lost;
    logic [SW-1:0]           r_scan_seq;
    logic [SW-1:0]           r_after;
    logic [SW-1:0]           r_pend_seq;
    logic [SW-1:0]           oldest_seq;
    logic [SW-1:0]           newest_seq;
    logic [PAYLOAD_BITS-1:0] r_mem [MAX_ENTRIES];
    logic [PAYLOAD_BITS-1:0] r_mem_q;
    logic [PAYLOAD_BITS-1:0] r_pend_pay;
    logic                    r_pend_valid;
    logic                    r_out_valid;
    logic                    r_out_last;
    logic                    r_out_user;
    logic [strb_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [SW-1:0]           sel_seq;
    logic [PW-1:0]           sel_pay;
    logic                    sel_user;
    logic                    sel_last;
    logic                    out_free;

    assign act_cap     = (r_cap > MAX_CNT) ? MAX_CNT : r_cap;
    assign limit_in    = (i_max_out > MAX_CNT) ? MAX_CNT : i_max_out;
    assign wp_inc      = ((CW'(r_wp) + CW'(1)) == act_cap) ? '0 : r_wp + AW'(1);
    assign slot_inc    = ((CW'(r_slot) + CW'(1)) == act_cap) ? '0 : r_slot + AW'(1);
    assign oldest_slot = (r_count < act_cap) ? '0 : r_wp;
    assign oldest_seq  = (r_count == '0) ? '0 : r_next - SW'(r_count);
    assign newest_seq  = (r_count == '0) ? '0 : r_next - SW'(1);
    assign out_free    = !r_out_valid || i_out_ready;

    assign o_stat.cap_zero      = (act_cap == '0);
    assign o_stat.collect_empty = (act_cap == '0) || (r_count == '0) || (limit_in == '0);
    assign o_stat.match         = (r_scan_seq > r_after);
    assign o_stat.scan_end      = ((r_i + CW'(1)) == r_count);
    assign o_stat.limit_hit     = ((r_n + CW'(1)) == r_limit);
    assign o_stat.pend_valid    = r_pend_valid;
    assign o_stat.out_free      = out_free;

    always_comb begin
        sel_seq  = r_pend_seq;
        sel_pay  = PW'(r_pend_pay);
        sel_user = 1'b1;
        sel_last = 1'b0;
        case (i_cmd.push)
            strb_pkg::PUSH_PEND: begin
                sel_last = 1'b0;
            end
            strb_pkg::PUSH_PEND_LAST: begin
                sel_last = 1'b1;
            end
            strb_pkg::PUSH_EMPTY: begin
                sel_seq  = '0;
                sel_pay  = '0;
                sel_user = 1'b0;
                sel_last = 1'b1;
            end
            default: begin
                sel_last = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap        <= CW'(64);
            r_wp         <= '0;
            r_count      <= '0;
            r_lost       <= '0;
            r_next       <= SW'(1);
            r_pend_valid <= 1'b0;
            r_n          <= '0;
            r_limit      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap   <= i_cfg_wdata;
                r_wp    <= '0;
                r_count <= '0;
                r_lost  <= '0;
                r_next  <= SW'(1);
            end else if (i_cmd.append) begin
                r_next <= r_next + SW'(1);
                r_wp   <= wp_inc;
                if (r_count < act_cap) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_lost <= r_lost + SW'(1);
                end
            end
            if (i_cmd.start) begin
                r_pend_valid <= 1'b0;
                r_n          <= '0;
                r_limit      <= limit_in;
            end
            if (i_cmd.take) begin
                r_pend_valid <= 1'b1;
                r_n          <= r_n + CW'(1);
            end
            if (i_cmd.push != strb_pkg::PUSH_NONE) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_slot     <= oldest_slot;
            r_i        <= '0;
            r_scan_seq <= oldest_seq;
            r_after    <= i_after_seq;
        end
        if (i_cmd.advance) begin
            r_slot     <= slot_inc;
            r_i        <= r_i + CW'(1);
            r_scan_seq <= r_scan_seq + SW'(1);
        end
        if (i_cmd.append) begin
            r_pend_seq <= r_next;
            r_pend_pay <= i_payload[PAYLOAD_BITS-1:0];
        end
        if (i_cmd.take) begin
            r_pend_seq <= r_scan_seq;
            r_pend_pay <= r_mem_q;
        end
        if (i_cmd.push != strb_pkg::PUSH_NONE) begin
            r_out_data <= {1'b0, r_lost, r_count, newest_seq, oldest_seq, sel_pay, sel_seq};
            r_out_last <= sel_last;
            r_out_user <= sel_user;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem[r_wp] <= i_payload[PAYLOAD_BITS-1:0];
        end
        r_mem_q <= r_mem[r_slot];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;
    assign o_out_user  = r_out_user;

    `STRB_ASSERT(a_count_within_cap, r_count <= act_cap)
    `STRB_ASSERT(a_push_needs_room, (i_cmd.push == strb_pkg::PUSH_NONE) || out_free)
    `STRB_ASSERT(a_taken_within_limit, r_n <= r_limit)
    `STRB_ASSERT_NEXT(a_append_steps_seq, i_cmd.append && !i_cfg_we, r_next == $past(r_next) + SW'(1))

endmodule

// File: hw/rtl/sequenced_trace_ring_buffer.sv
// Trace ring buffer with 32-bit sequence numbers. An append (tuser 0) stores the payload in
// the next ring slot, numbered from 1 and wrapping; once the ring holds ring_capacity entries
// the oldest is overwritten and the overwrite count rises. A collect (tuser 1) walks the ring
// from oldest to newest and returns every entry whose sequence exceeds after_seq, up to
// max_out, with tlast on the final one; when nothing qualifies one result with tuser 0 comes
// back. Every result carries the ring status (oldest and newest sequence, entry count,
// overwrite count). Writing ring_capacity clears the ring; 0 disables it. An append's result
// passes through the pending register to the output register. A collect scans each entry
// with a registered read of the sample memory followed by the compare. A new transfer is
// accepted once the previous item is finished while its last result may still wait in the
// output register.
module sequenced_trace_ring_buffer #(
    parameter int MAX_ENTRIES  = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [strb_pkg::CNT_W-1:0]          i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // payload[31:0], after_seq[63:32], max_out[70:64], zero[71]
    input  logic [strb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // operation[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // result_seq[31:0], result_payload[63:32], oldest_seq[95:64], newest_seq[127:96],
    // entry_count[134:128], overwrite_count[166:135], zero[167]
    output logic [strb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // result_valid[0]
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);

    strb_pkg::t_cmd  cmd;
    strb_pkg::t_stat stat;

    strb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    strb_datapath #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_payload   (s_axis_tdata[31:0]),
        .i_after_seq (s_axis_tdata[63:32]),
        .i_max_out   (s_axis_tdata[70:64]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_user  (m_axis_tuser)
    );

endmodule
